[hw/rtl/url_percent_decoder_defines.svh]
// assertion macros for the url percent decoder checker
// expects clk_i and rst_ni to be visible where the macros are used
`ifndef URL_PERCENT_DECODER_DEFINES_SVH
`define URL_PERCENT_DECODER_DEFINES_SVH

// same-cycle implication, disabled in reset
`define UPD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("upd assertion failed");

// next-cycle implication, disabled in reset
`define UPD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("upd assertion failed");

`endif

[hw/rtl/upd_pkg.sv]
// shared types, character constants and hex helpers for the url percent decoder
// no dependencies
`default_nettype none

package upd_pkg;

  localparam logic [7:0] PctChar   = 8'h25;
  localparam logic [7:0] PlusChar  = 8'h2B;
  localparam logic [7:0] SpaceChar = 8'h20;

  localparam int unsigned MaxRes = 3;

  // escape phase codes
  localparam logic [1:0] PhIdle = 2'd0;
  localparam logic [1:0] PhPct  = 2'd1;
  localparam logic [1:0] PhHex  = 2'd2;

  // results caused by one input beat
  typedef struct packed {
    logic [MaxRes-1:0][7:0] data;
    logic [1:0]             cnt;
    logic                   last;
  } upd_grp_t;

  function automatic logic is_hex(input logic [7:0] c);
    return ((c >= 8'h30) && (c <= 8'h39)) ||
           ((c >= 8'h41) && (c <= 8'h46)) ||
           ((c >= 8'h61) && (c <= 8'h66));
  endfunction

  function automatic logic [3:0] hex_nib(input logic [7:0] c);
    logic [3:0] v;
    if (c <= 8'h39) begin
      v = c[3:0];
    end else begin
      v = c[3:0] + 4'd9;
    end
    return v;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/upd_decode.sv]
// escape state and per-beat decode into a group of up to three result bytes
// depends on upd_pkg
`default_nettype none

module upd_decode (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic [7:0]      byte_i,
  input  wire logic            last_i,
  input  wire logic            adv_i,
  output upd_pkg::upd_grp_t    grp_o
);
  import upd_pkg::*;

  logic [1:0] phase_q, phase_d;
  logic [7:0] held_q, held_d;

  always_comb begin
    logic [MaxRes-1:0][7:0] data;
    logic [1:0]             cnt;
    logic                   do_idle;
    data    = '0;
    cnt     = 2'd0;
    do_idle = 1'b0;
    phase_d = phase_q;
    held_d  = held_q;

    case (phase_q)
      PhPct: begin
        if (is_hex(byte_i)) begin
          phase_d = PhHex;
          held_d  = byte_i;
        end else begin
          data[cnt] = PctChar;
          cnt       = cnt + 2'd1;
          phase_d   = PhIdle;
          do_idle   = 1'b1;
        end
      end
      PhHex: begin
        phase_d = PhIdle;
        if (is_hex(byte_i) && is_hex(held_q)) begin
          data[cnt] = {hex_nib(held_q), hex_nib(byte_i)};
          cnt       = cnt + 2'd1;
        end else begin
          data[cnt] = PctChar;
          cnt       = cnt + 2'd1;
          data[cnt] = held_q;
          cnt       = cnt + 2'd1;
          do_idle   = 1'b1;
        end
      end
      default: begin
        phase_d = PhIdle;
        do_idle = 1'b1;
      end
    endcase

    if (do_idle) begin
      if (byte_i == PctChar) begin
        phase_d = PhPct;
      end else if (byte_i == PlusChar) begin
        data[cnt] = SpaceChar;
        cnt       = cnt + 2'd1;
      end else begin
        data[cnt] = byte_i;
        cnt       = cnt + 2'd1;
      end
    end

    // flush a pending escape at end of stream
    if (last_i) begin
      if (phase_d == PhPct) begin
        data[cnt] = PctChar;
        cnt       = cnt + 2'd1;
      end else if (phase_d == PhHex) begin
        data[cnt] = PctChar;
        cnt       = cnt + 2'd1;
        data[cnt] = held_d;
        cnt       = cnt + 2'd1;
      end
      phase_d = PhIdle;
    end

    if (phase_d == PhIdle) begin
      held_d = 8'h00;
    end

    grp_o.data = data;
    grp_o.cnt  = cnt;
    grp_o.last = last_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      held_q  <= 8'h00;
    end else if (adv_i) begin
      phase_q <= phase_d;
      held_q  <= held_d;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/upd_emit.sv]
// result register that hands out a decoded group one byte per beat
// depends on upd_pkg
`default_nettype none

module upd_emit (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire upd_pkg::upd_grp_t grp_i,
  input  wire logic              load_i,
  output logic                   free_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [7:0]             out_byte_o,
  output logic                   run_end_o,
  output logic                   stream_end_o
);
  import upd_pkg::*;

  logic [1:0]             cnt_q, cnt_d;
  logic [1:0]             idx_q, idx_d;
  logic [MaxRes-1:0][7:0] data_q;
  logic                   last_q;
  logic                   take;
  logic                   done;

  assign out_valid_o  = (cnt_q != 2'd0);
  assign run_end_o    = ((idx_q + 2'd1) == cnt_q);
  assign stream_end_o = run_end_o & last_q;
  assign take         = out_valid_o & out_ready_i;
  assign done         = take & run_end_o;
  assign free_o       = !out_valid_o || done;

  always_comb begin
    case (idx_q)
      2'd0:    out_byte_o = data_q[0];
      2'd1:    out_byte_o = data_q[1];
      2'd2:    out_byte_o = data_q[2];
      default: out_byte_o = data_q[0];
    endcase
  end

  always_comb begin
    cnt_d = cnt_q;
    idx_d = idx_q;
    if (load_i) begin
      cnt_d = grp_i.cnt;
      idx_d = 2'd0;
    end else if (done) begin
      cnt_d = 2'd0;
      idx_d = 2'd0;
    end else if (take) begin
      idx_d = idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
      idx_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      idx_q <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= grp_i.data;
      last_q <= grp_i.last;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/url_percent_decoder.sv]
// url percent decoder: an input beat passes the input register, then the result register.
// one input beat per cycle while each beat yields at most one byte and the output is ready;
// a beat that yields n bytes holds the result register until its n bytes have been taken.
// beats inside an escape yield nothing and pass without using the output.
// rst_ni clears the escape state, the input register and the result register.
`default_nettype none

module url_percent_decoder (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] in_byte_i,
  input  wire logic       in_last_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [7:0]      out_byte_o,
  output logic            run_end_o,
  output logic            stream_end_o
);
  import upd_pkg::*;

  logic       iv_q, iv_d;
  logic [7:0] byte_q;
  logic       last_q;
  logic       adv;
  logic       load;
  logic       free;
  upd_grp_t   grp;

  // input register moves on when the result register can take its group or the group is empty
  assign adv        = iv_q && (free || (grp.cnt == 2'd0));
  assign load       = adv && (grp.cnt != 2'd0);
  assign in_ready_o = !iv_q || adv;

  always_comb begin
    iv_d = iv_q;
    if (in_valid_i && in_ready_o) begin
      iv_d = 1'b1;
    end else if (adv) begin
      iv_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iv_q <= 1'b0;
    end else begin
      iv_q <= iv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      byte_q <= in_byte_i;
      last_q <= in_last_i;
    end
  end

  upd_decode u_decode (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .byte_i (byte_q),
    .last_i (last_q),
    .adv_i  (adv),
    .grp_o  (grp)
  );

  upd_emit u_emit (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .grp_i        (grp),
    .load_i       (load),
    .free_o       (free),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_byte_o   (out_byte_o),
    .run_end_o    (run_end_o),
    .stream_end_o (stream_end_o)
  );

endmodule

`default_nettype wire

[hw/rtl/upd_checker.sv]
// port-level checks for the url percent decoder, bound to the top level
// depends on url_percent_decoder_defines.svh
`default_nettype none

`include "url_percent_decoder_defines.svh"

module upd_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_ready_i,
  input wire logic       out_valid_i,
  input wire logic       out_ready_i,
  input wire logic [7:0] out_byte_i,
  input wire logic       run_end_i,
  input wire logic       stream_end_i
);

  // stalled result beat holds
  `UPD_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i,
    out_valid_i && $stable(out_byte_i) && $stable(run_end_i) && $stable(stream_end_i))

  // end of stream closes a run
  `UPD_ASSERT_NOW(a_stream_run, out_valid_i && stream_end_i, run_end_i)

  // bytes of one run come without gaps
  `UPD_ASSERT_NEXT(a_run_cont, out_valid_i && out_ready_i && !run_end_i, out_valid_i)

  // empty output side never stalls the input
  `UPD_ASSERT_NOW(a_idle_ready, !out_valid_i, in_ready_i)

endmodule

bind url_percent_decoder upd_checker u_upd_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_ready_i   (in_ready_o),
  .out_valid_i  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .out_byte_i   (out_byte_o),
  .run_end_i    (run_end_o),
  .stream_end_i (stream_end_o)
);

`default_nettype wire

[tb/url_percent_decoder_chk.sv]
`timescale 1ns / 1ps
// checker for the url percent decoder: watches both channels, predicts the decoded
// bytes of every accepted input beat and compares them with the output beats
// depends on upd_pkg for the character and escape phase constants
module url_percent_decoder_chk (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  input  wire logic       in_ready_i,
  input  wire logic [7:0] in_byte_i,
  input  wire logic       in_last_i,
  input  wire logic       out_valid_i,
  input  wire logic       out_ready_i,
  input  wire logic [7:0] out_byte_i,
  input  wire logic       run_end_i,
  input  wire logic       stream_end_i,
  output int              err_cnt_o,
  output int              pend_cnt_o,
  output int              chk_cnt_o
);
  import upd_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic       run_end;
    logic       stream_end;
  } dec_byte_t;

  dec_byte_t  decoded_q[$];
  logic [7:0] emit_q[$];
  logic [1:0] esc_ph;
  logic [7:0] held_digit;

  initial begin
    err_cnt_o  = 0;
    pend_cnt_o = 0;
    chk_cnt_o  = 0;
    esc_ph     = PhIdle;
    held_digit = 8'h00;
  end

  function automatic logic hex_ok(input logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "A" && c <= "F") || (c >= "a" && c <= "f");
  endfunction

  function automatic logic [3:0] nib_val(input logic [7:0] c);
    logic [7:0] v;
    if (c >= "a") begin
      v = c - "a" + 8'd10;
    end else if (c >= "A") begin
      v = c - "A" + 8'd10;
    end else begin
      v = c - "0";
    end
    return v[3:0];
  endfunction

  function automatic void decode_plain(input logic [7:0] b);
    if (b == PctChar) begin
      esc_ph = PhPct;
    end else if (b == PlusChar) begin
      emit_q.push_back(SpaceChar);
    end else begin
      emit_q.push_back(b);
    end
  endfunction

  // expected output beats of one input beat
  function automatic void decode_beat(input logic [7:0] b, input logic l);
    dec_byte_t e;
    emit_q.delete();
    case (esc_ph)
      PhPct: begin
        if (hex_ok(b)) begin
          held_digit = b;
          esc_ph = PhHex;
        end else begin
          esc_ph = PhIdle;
          emit_q.push_back(PctChar);
          decode_plain(b);
        end
      end
      PhHex: begin
        esc_ph = PhIdle;
        if (hex_ok(b)) begin
          emit_q.push_back({nib_val(held_digit), nib_val(b)});
        end else begin
          emit_q.push_back(PctChar);
          emit_q.push_back(held_digit);
          decode_plain(b);
        end
        held_digit = 8'h00;
      end
      default: begin
        esc_ph = PhIdle;
        decode_plain(b);
      end
    endcase
    // flush a cut-short escape at end of stream
    if (l) begin
      if (esc_ph == PhPct) begin
        emit_q.push_back(PctChar);
      end else if (esc_ph == PhHex) begin
        emit_q.push_back(PctChar);
        emit_q.push_back(held_digit);
      end
      esc_ph = PhIdle;
      held_digit = 8'h00;
    end
    foreach (emit_q[k]) begin
      e.data = emit_q[k];
      e.run_end = (k == emit_q.size() - 1);
      e.stream_end = e.run_end && l;
      decoded_q.push_back(e);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    dec_byte_t e;
    if (!rst_ni) begin
      esc_ph = PhIdle;
      held_digit = 8'h00;
      decoded_q.delete();
      pend_cnt_o <= 0;
    end else begin
      if (in_valid_i && in_ready_i) begin
        decode_beat(in_byte_i, in_last_i);
      end
      if (out_valid_i && out_ready_i) begin
        if (decoded_q.size() == 0) begin
          err_cnt_o = err_cnt_o + 1;
          $display("%0t unexpected beat: expected none, actual byte %h run_end %b stream_end %b",
                   $time, out_byte_i, run_end_i, stream_end_i);
        end else begin
          e = decoded_q.pop_front();
          chk_cnt_o = chk_cnt_o + 1;
          if (e.data !== out_byte_i) begin
            err_cnt_o = err_cnt_o + 1;
            $display("%0t out_byte mismatch: expected %h actual %h",
                     $time, e.data, out_byte_i);
          end
          if (e.run_end !== run_end_i) begin
            err_cnt_o = err_cnt_o + 1;
            $display("%0t run_end mismatch: expected %b actual %b",
                     $time, e.run_end, run_end_i);
          end
          if (e.stream_end !== stream_end_i) begin
            err_cnt_o = err_cnt_o + 1;
            $display("%0t stream_end mismatch: expected %b actual %b",
                     $time, e.stream_end, stream_end_i);
          end
        end
      end
      pend_cnt_o <= decoded_q.size();
    end
  end

endmodule

[tb/url_percent_decoder_tb.sv]
`timescale 1ns / 1ps
// top of the url percent decoder testbench: clock, reset, byte stimulus and verdict
// depends on url_percent_decoder, url_percent_decoder_chk and upd_pkg
module url_percent_decoder_tb;
  import upd_pkg::*;

  logic       clk_i     = 1'b0;
  logic       rst_ni    = 1'b0;
  logic       in_valid  = 1'b0;
  logic [7:0] in_byte   = 8'h00;
  logic       in_last   = 1'b0;
  logic       out_ready = 1'b0;
  wire        in_ready;
  wire        out_valid;
  wire  [7:0] out_byte;
  wire        run_end;
  wire        stream_end;

  int err_cnt;
  int pend_cnt;
  int chk_cnt;
  int sent_cnt   = 0;
  int stream_cnt = 0;
  int burst_left = 0;
  int ready_mode = 0;
  int mode_left  = 0;

  url_percent_decoder dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_byte_i   (in_byte),
    .in_last_i   (in_last),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_byte_o  (out_byte),
    .run_end_o   (run_end),
    .stream_end_o(stream_end)
  );

  url_percent_decoder_chk chk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .in_byte_i   (in_byte),
    .in_last_i   (in_last),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .out_byte_i  (out_byte),
    .run_end_i   (run_end),
    .stream_end_i(stream_end),
    .err_cnt_o   (err_cnt),
    .pend_cnt_o  (pend_cnt),
    .chk_cnt_o   (chk_cnt)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // receiver: always ready, mostly ready, mostly stalled, or periodic stalls
  always @(posedge clk_i) begin
    if (mode_left == 0) begin
      ready_mode <= $urandom_range(0, 3);
      mode_left <= $urandom_range(8, 80);
    end else begin
      mode_left <= mode_left - 1;
    end
    case (ready_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 3) != 0);
      2: out_ready <= ($urandom_range(0, 3) == 0);
      default: out_ready <= (mode_left % 5 != 0);
    endcase
  end

  task automatic send_beat(input logic [7:0] b, input logic l);
    int gap;
    in_valid <= 1'b1;
    in_byte <= b;
    in_last <= l;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    sent_cnt++;
    if (l) stream_cnt++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 24) : $urandom_range(0, 4);
      burst_left = $urandom_range(1, 40);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  task automatic send_str(input string s, input logic l);
    for (int i = 0; i < s.len(); i++) begin
      send_beat(s[i], l && (i == s.len() - 1));
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pend_cnt != 0) @(posedge clk_i);
  endtask

  function automatic logic [7:0] rand_hex();
    case ($urandom_range(0, 2))
      0: return 8'(8'h30 + $urandom_range(0, 9));
      1: return 8'(8'h41 + $urandom_range(0, 5));
      default: return 8'(8'h61 + $urandom_range(0, 5));
    endcase
  endfunction

  // non-hex bytes, weighted toward the edges of the digit ranges
  function automatic logic [7:0] rand_non_hex();
    case ($urandom_range(0, 3))
      0: return 8'($urandom_range(8'h00, 8'h2F));
      1: return 8'($urandom_range(8'h3A, 8'h40));
      2: return 8'($urandom_range(8'h47, 8'h60));
      default: return 8'($urandom_range(8'h67, 8'hFF));
    endcase
  endfunction

  function automatic logic rand_last();
    return ($urandom_range(0, 11) == 0);
  endfunction

  initial begin
    int k;
    int next_drain;
    int rnd_base;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // directed: extremes, both hex cases, broken and cut-short escapes
    send_beat(8'h00, 1'b0);
    send_beat(8'hFF, 1'b0);
    send_str("%41", 1'b0);
    send_str("%fF", 1'b0);
    send_str("%G", 1'b0);
    send_str("%a+", 1'b0);
    send_str("%%09", 1'b0);
    send_str("%", 1'b1);
    send_str("%B", 1'b1);
    send_str("%7e", 1'b1);
    send_str("%4/", 1'b1);
    wait_drained();

    rnd_base = sent_cnt;
    next_drain = sent_cnt + $urandom_range(80, 160);
    while (sent_cnt - rnd_base < 470) begin
      k = $urandom_range(0, 19);
      if (k < 10) begin
        send_beat(PctChar, rand_last());
        send_beat(rand_hex(), rand_last());
        send_beat(rand_hex(), rand_last());
      end else if (k < 13) begin
        send_beat(8'($urandom_range(0, 255)), rand_last());
      end else if (k < 15) begin
        send_beat(PlusChar, rand_last());
      end else if (k < 17) begin
        send_beat(PctChar, rand_last());
        send_beat(rand_non_hex(), rand_last());
      end else if (k < 19) begin
        send_beat(PctChar, rand_last());
        send_beat(rand_hex(), rand_last());
        send_beat(rand_non_hex(), rand_last());
      end else begin
        send_beat(PctChar, rand_last());
        send_beat(rand_hex(), rand_last());
        send_beat(PctChar, rand_last());
      end
      if (sent_cnt >= next_drain) begin
        wait_drained();
        next_drain = sent_cnt + $urandom_range(80, 160);
      end
    end

    wait_drained();
    repeat (20) @(posedge clk_i);
    $display("sent %0d input beats over %0d streams, checked %0d decoded bytes",
             sent_cnt, stream_cnt, chk_cnt);
    if (err_cnt == 0 && pend_cnt == 0) begin
      $display("[url_percent_decoder] OK");
    end else begin
      $display("[url_percent_decoder] ERROR");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("timeout with %0d decoded bytes outstanding", pend_cnt);
    $display("[url_percent_decoder] ERROR");
    $finish;
  end

endmodule
